@@ hdl/spa_pkg.sv @@
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants of the stationary pixel accumulator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int PIXELS     = 524288;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_BITS  = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  localparam int MASK_BITS  = 8;
  localparam int INDEX_BITS = 19;
  localparam int CONF_BITS  = 16;
  localparam int THR_BITS   = 16;
  localparam int COST_BITS  = 8;
  localparam int CFG_BITS   = 16;

  // The sum base + inc - dec needs a sign bit and one bit of headroom.
  localparam int SUM_BITS   = COUNT_BITS + 2;
  // Common width for comparing the counter with 16-bit quantities.
  localparam int WIDE_BITS  = (COUNT_BITS > CONF_BITS) ? COUNT_BITS : CONF_BITS;

  localparam logic [MASK_BITS-1:0] SHADOW_VALUE = 8'd127;
  localparam logic [MASK_BITS-1:0] FULL_FG      = 8'd255;

  localparam logic [THR_BITS-1:0]  FRAMES_TO_STATIC_RST = 16'd300;
  localparam logic [COST_BITS-1:0] INCREMENT_COST_RST   = 8'd1;
  localparam logic [COST_BITS-1:0] DECREMENT_COST_RST   = 8'd10;

  typedef enum logic [1:0] {
    CFG_FRAMES_TO_STATIC,
    CFG_INCREMENT_COST,
    CFG_DECREMENT_COST
  } spa_cfg_idx_t;

  // One write request into the accumulator store.
  typedef struct packed {
    logic                  en;
    logic [ADDR_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] data;
  } spa_wr_t;

endpackage

@@ hdl/stationary_pixel_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// stationary_pixel_accumulator_core
// Per-pixel saturating foreground accumulator with static-pixel flag.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   mask_value, pixel_index
//   out      output     out_valid / out_stall static_flag, confidence
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// One request is accepted per cycle while in_stall is low; a result passes
// through the registered read of the counter store and the update stage
// into the output register.
// After reset a clearing pass zeroes all PIXELS (524288) entries of the
// store, one entry per cycle; no request is accepted during that pass.
// A stalled output holds one result and one more request in the update
// stage; further requests are stalled until the output drains.
// ----------------------------------------------------------------------------
module stationary_pixel_accumulator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [spa_pkg::MASK_BITS-1:0]   mask_value,
  input  logic [spa_pkg::INDEX_BITS-1:0]  pixel_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            static_flag,
  output logic [spa_pkg::CONF_BITS-1:0]   confidence,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [spa_pkg::CFG_BITS-1:0]    cfg_data
);
  import spa_pkg::*;

  // Configuration registers.
  logic [THR_BITS-1:0]  frames_to_static;
  logic [COST_BITS-1:0] increment_cost;
  logic [COST_BITS-1:0] decrement_cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_to_static <= FRAMES_TO_STATIC_RST;
      increment_cost   <= INCREMENT_COST_RST;
      decrement_cost   <= DECREMENT_COST_RST;
    end else if (cfg_write) begin
      case (spa_cfg_idx_t'(cfg_index))
        CFG_FRAMES_TO_STATIC: frames_to_static <= cfg_data[THR_BITS-1:0];
        CFG_INCREMENT_COST:   increment_cost   <= cfg_data[COST_BITS-1:0];
        CFG_DECREMENT_COST:   decrement_cost   <= cfg_data[COST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset.
  logic                 clr_active;
  logic [ADDR_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == ADDR_BITS'(PIXELS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Input decode.
  logic [INDEX_BITS+ADDR_BITS-1:0] idx_ext;
  logic [ADDR_BITS-1:0]            in_addr;
  logic                            in_range;
  logic                            in_fg;
  logic                            in_dec;
  logic                            in_acc;

  assign idx_ext  = {{ADDR_BITS{1'b0}}, pixel_index};
  assign in_addr  = idx_ext[ADDR_BITS-1:0];
  assign in_range = 32'(pixel_index) < 32'(PIXELS);
  // Shadow counts as background; everything else but full foreground decays.
  assign in_fg    = (mask_value != '0) && (mask_value != SHADOW_VALUE);
  assign in_dec   = (mask_value != FULL_FG);

  // Update stage.
  logic                  s1_valid;
  logic                  s1_range;
  logic                  s1_fg;
  logic                  s1_dec;
  logic [ADDR_BITS-1:0]  s1_addr;
  logic                  s1_fwd;
  logic [COUNT_BITS-1:0] s1_fwd_data;
  logic                  s1_adv;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] base;
  logic [SUM_BITS-1:0]   sum;
  logic [COUNT_BITS-1:0] upd;
  logic [WIDE_BITS-1:0]  upd_w;
  logic                  res_flag;
  logic [CONF_BITS-1:0]  res_conf;
  spa_wr_t               wr;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clr_active || (s1_valid && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
      // The previous update is written at this same edge, after the read.
      s1_fwd   <= s1_adv && s1_range && (s1_addr == in_addr);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_range    <= in_range;
      s1_fg       <= in_fg;
      s1_dec      <= in_dec;
      s1_addr     <= in_addr;
      s1_fwd_data <= upd;
    end
  end

  assign base = s1_fwd ? s1_fwd_data : rd_data;

  always_comb begin
    sum = SUM_BITS'(base);
    if (s1_fg) begin
      sum = sum + SUM_BITS'(increment_cost);
    end
    if (s1_dec) begin
      sum = sum - SUM_BITS'(decrement_cost);
    end
    if (sum[SUM_BITS-1]) begin
      upd = '0;
    end else if (sum[SUM_BITS-2]) begin
      upd = {COUNT_BITS{1'b1}};
    end else begin
      upd = sum[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    upd_w = WIDE_BITS'(upd);
    if (!s1_range) begin
      res_flag = 1'b0;
      res_conf = '0;
    end else begin
      res_flag = upd_w >= WIDE_BITS'(frames_to_static);
      res_conf = (upd_w > WIDE_BITS'({CONF_BITS{1'b1}})) ? {CONF_BITS{1'b1}}
                                                          : upd_w[CONF_BITS-1:0];
    end
  end

  always_comb begin
    if (clr_active) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr;
      wr.data = '0;
    end else begin
      wr.en   = s1_adv && s1_range;
      wr.addr = s1_addr;
      wr.data = upd;
    end
  end

  spa_acc_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (in_acc),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      static_flag <= res_flag;
      confidence  <= res_conf;
    end
  end

`ifndef SYNTHESIS
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> (!s1_valid && !out_valid))
    else $error("activity during the clearing pass");

  a_fwd_valid: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> s1_valid)
    else $error("forwarding flag set without an update in flight");

  a_held_base: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> $stable(base))
    else $error("counter of a stalled update changed");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    (wr.en && !clr_active) |=> !(wr.en && s1_valid && $stable(s1_addr) && !$past(in_acc)))
    else $error("update written twice");
`endif

endmodule

@@ hdl/spa_acc_ram.sv @@
// ----------------------------------------------------------------------------
// spa_acc_ram
// Single-port-write, single-port-read store of the per-pixel counters,
// with registered read data.
// ----------------------------------------------------------------------------
module spa_acc_ram (
  input  logic                           clk,
  input  spa_pkg::spa_wr_t               wr,
  input  logic                           rd_en,
  input  logic [spa_pkg::ADDR_BITS-1:0]  rd_addr,
  output logic [spa_pkg::COUNT_BITS-1:0] rd_data
);
  import spa_pkg::*;

  logic [COUNT_BITS-1:0] mem [PIXELS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read happens before the write of the same edge lands.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stationary pixel accumulator core.
// Requests of mask value and pixel index are sent through a valid/stall
// channel, and each one is scored in a local per-pixel counter model. Every
// result is checked against the oldest prediction. The run steps through
// several threshold and cost settings, including the extremes and counter
// saturation, under varying sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;

  localparam longint LEVEL_MAX = (longint'(1) << COUNT_BITS) - 1;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [MASK_BITS-1:0]  mask;
    logic [INDEX_BITS-1:0] index;
  } pixel_req_t;

  typedef struct packed {
    logic                 flag;
    logic [CONF_BITS-1:0] conf;
  } pixel_result_t;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [MASK_BITS-1:0]  mask_value  = '0;
  logic [INDEX_BITS-1:0] pixel_index = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  static_flag;
  logic [CONF_BITS-1:0]  confidence;
  logic                  cfg_write   = 1'b0;
  logic [1:0]            cfg_index   = CFG_FRAMES_TO_STATIC;
  logic [CFG_BITS-1:0]   cfg_data    = '0;

  // Model of the block: per-pixel counters and the three registers.
  longint        pixel_level [int unsigned];
  int            static_level = int'(FRAMES_TO_STATIC_RST);
  int            inc_cost     = int'(INCREMENT_COST_RST);
  int            dec_cost     = int'(DECREMENT_COST_RST);

  pixel_req_t    pixel_req_q[$];
  pixel_result_t level_expect_q[$];
  int            reqs_queued   = 0;
  int            reqs_accepted = 0;
  int            mismatch_count = 0;
  logic          req_taken = 1'b0;
  idle_mode_t    idle_mode = IDLE_NONE;
  logic [INDEX_BITS-1:0] hot_pixels [8];

  stationary_pixel_accumulator_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mask_value  (mask_value),
    .pixel_index (pixel_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .static_flag (static_flag),
    .confidence  (confidence),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic pixel_result_t accumulate_pixel(input pixel_req_t req);
    pixel_result_t        res;
    logic [MASK_BITS-1:0] v;
    longint               level;
    v = (req.mask == SHADOW_VALUE) ? '0 : req.mask;
    level = pixel_level.exists(req.index) ? pixel_level[req.index] : 0;
    if (v != '0) level += inc_cost;
    if (v != FULL_FG) level -= dec_cost;
    if (level < 0) level = 0;
    if (level > LEVEL_MAX) level = LEVEL_MAX;
    pixel_level[req.index] = level;
    res.flag = (level >= static_level);
    res.conf = (level > 65535) ? 16'hFFFF : level[CONF_BITS-1:0];
    return res;
  endfunction

  function automatic logic rests(input int pct);
    return ($urandom_range(99) < pct);
  endfunction

  // Request driver: a request stays on the port until it has been taken.
  always @(negedge clk) begin
    pixel_req_t nxt;
    logic       hold;
    hold = in_valid && !req_taken;
    if (!hold) begin
      if (pixel_req_q.size() > 0 &&
          !rests(idle_mode == IDLE_SENDER ? 62 : idle_mode == IDLE_BOTH ? 16 : 0)) begin
        nxt = pixel_req_q.pop_front();
        in_valid    <= 1'b1;
        mask_value  <= nxt.mask;
        pixel_index <= nxt.index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rests(idle_mode == IDLE_RECEIVER ? 62 : idle_mode == IDLE_BOTH ? 16 : 0);
  end

  // Monitor: predicts on each accepted request and scores each accepted result.
  always @(posedge clk) begin
    pixel_result_t exp_res;
    req_taken = 1'b0;
    if (!rst) begin
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        level_expect_q.push_back(accumulate_pixel({mask_value, pixel_index}));
        reqs_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (level_expect_q.size() == 0) begin
          $error("unexpected result: static_flag %0d confidence %0d", static_flag, confidence);
          mismatch_count++;
        end else begin
          exp_res = level_expect_q.pop_front();
          if (static_flag !== exp_res.flag) begin
            $error("static_flag: expected %0d, got %0d", exp_res.flag, static_flag);
            mismatch_count++;
          end
          if (confidence !== exp_res.conf) begin
            $error("confidence: expected %0d, got %0d", exp_res.conf, confidence);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic push_pixel(input logic [MASK_BITS-1:0] mask,
                            input logic [INDEX_BITS-1:0] index);
    pixel_req_q.push_back({mask, index});
    reqs_queued++;
  endtask

  // Waits until every request has been taken and answered, then lets the
  // pipeline settle.
  task automatic drain();
    while (reqs_accepted != reqs_queued || level_expect_q.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input spa_cfg_idx_t idx, input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_FRAMES_TO_STATIC: static_level = int'(value);
      CFG_INCREMENT_COST:   inc_cost     = int'(value[COST_BITS-1:0]);
      CFG_DECREMENT_COST:   dec_cost     = int'(value[COST_BITS-1:0]);
      default: ;
    endcase
  endtask

  // Cost registers get random upper bits, which the block must ignore.
  task automatic configure(input int thr, input int inc, input int dec);
    drain();
    write_reg(CFG_FRAMES_TO_STATIC, 16'(thr));
    write_reg(CFG_INCREMENT_COST, {8'($urandom_range(255)), 8'(inc)});
    write_reg(CFG_DECREMENT_COST, {8'($urandom_range(255)), 8'(dec)});
  endtask

  task automatic send_random(input int n, input idle_mode_t mode, input int hot_count,
                             input int hot_pct, input int fg_pct);
    logic [MASK_BITS-1:0]  mask;
    logic [INDEX_BITS-1:0] index;
    idle_mode = mode;
    repeat (n) begin
      if (rests(fg_pct)) begin
        mask = FULL_FG;
      end else begin
        case ($urandom_range(3))
          0:       mask = '0;
          1:       mask = SHADOW_VALUE;
          default: mask = MASK_BITS'($urandom_range(255));
        endcase
      end
      if (rests(hot_pct)) index = hot_pixels[3'($urandom_range(hot_count - 1))];
      else index = INDEX_BITS'($urandom_range(PIXELS - 1));
      push_pixel(mask, index);
    end
    while (pixel_req_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    hot_pixels[0] = '0;
    hot_pixels[1] = INDEX_BITS'(PIXELS - 1);
    for (int i = 2; i < 8; i++) hot_pixels[i] = INDEX_BITS'($urandom_range(PIXELS - 1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: foreground climbs slowly, shadow and background clamp at zero.
    push_pixel(FULL_FG, '0);
    push_pixel(FULL_FG, '0);
    push_pixel(SHADOW_VALUE, '0);
    push_pixel(8'd0, '0);
    push_pixel(FULL_FG, INDEX_BITS'(PIXELS - 1));
    push_pixel(8'd1, INDEX_BITS'(PIXELS - 1));

    // Mid values take both costs; the first lands exactly on the threshold.
    configure(150, 200, 50);
    push_pixel(8'd128, 19'd5);
    push_pixel(8'd254, 19'd5);
    push_pixel(SHADOW_VALUE, 19'd5);
    push_pixel(8'd0, 19'd5);
    push_pixel(FULL_FG, 19'd5);
    push_pixel(8'd1, 19'd5);
    push_pixel(FULL_FG, INDEX_BITS'(PIXELS - 1));
    push_pixel(8'd0, INDEX_BITS'(PIXELS - 1));
    push_pixel(SHADOW_VALUE, INDEX_BITS'(PIXELS - 1));
    drain();

    // Zero threshold with zero costs: every pixel is static and nothing moves.
    configure(0, 0, 0);
    send_random(40, IDLE_SENDER, 8, 60, 30);

    // Largest threshold and increment: one pixel is driven into saturation.
    configure(65535, 255, 0);
    for (int k = 0; k < 4; k++) send_random(75, idle_mode_t'(k), 1, 100, 90);

    // Heavy decay pulls the saturated pixel back down.
    configure(1, 1, 255);
    send_random(30, IDLE_BOTH, 4, 80, 30);
    send_random(30, IDLE_RECEIVER, 4, 80, 60);

    repeat (3) begin
      configure($urandom_range(600), $urandom_range(255), $urandom_range(255));
      send_random(40, idle_mode_t'($urandom_range(3)), 8, 70, 40);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // The store clearing pass alone has to zero over half a million entries.
  initial begin
    #16_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/spa_pkg.sv
hdl/spa_acc_ram.sv
hdl/stationary_pixel_accumulator_core.sv
sim/tb_top.sv
